/* hdl/hsd_pkg.sv */
// ----------------------------------------------------------------------------
// hsd_pkg
// Types, constants and saturation helpers for the homography steepest
// descent pixel pipeline.
// ----------------------------------------------------------------------------
package hsd_pkg;

   localparam int COORD_BITS = 13;
   localparam int COEF_W     = 48;
   localparam int NUM_COEF   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int GRAD_W     = 32;
   localparam int GRAD_FRAC  = 16;
   localparam int INT_FRAC   = 32;
   localparam int OUT_FRAC   = 24;
   localparam int QUO_BITS   = 64;

   localparam int LAT_IN   = 1;
   localparam int LAT_AFF  = 2;
   localparam int LAT_DIV  = QUO_BITS + 2;
   localparam int LAT_PROJ = 3;
   localparam int LAT_OUT  = 2;
   localparam int LAT_ALL  = LAT_IN + LAT_AFF + LAT_DIV + LAT_PROJ + LAT_OUT;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_00 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_11 = 3'd4;

   typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]    col;
      logic [COORD_BITS-1:0]    row;
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] jac_x_gx;
      logic signed [COEF_W-1:0] jac_x_gy;
      logic signed [COEF_W-1:0] jac_x_proj;
      logic signed [COEF_W-1:0] jac_y_gx;
      logic signed [COEF_W-1:0] jac_y_gy;
      logic signed [COEF_W-1:0] jac_y_proj;
      logic signed [COEF_W-1:0] jac_gx;
      logic signed [COEF_W-1:0] jac_gy;
      logic                     degenerate;
   } rsp_type;

   function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
      logic signed [63:0] r;
      if ((&v[127:63]) || !(|v[127:63])) begin
         r = v[63:0];
      end else if (v[127]) begin
         r = {1'b1, 63'd0};
      end else begin
         r = {1'b0, {63{1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [COEF_W-1:0] sat48(input logic signed [127:0] v);
      logic signed [COEF_W-1:0] r;
      if ((&v[127:COEF_W-1]) || !(|v[127:COEF_W-1])) begin
         r = v[COEF_W-1:0];
      end else if (v[127]) begin
         r = {1'b1, {(COEF_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COEF_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

/* hdl/hsd_affine.sv */
// ----------------------------------------------------------------------------
// hsd_affine
// Two-stage affine unit: coordinate products, then the projective
// denominator and both projection numerators, saturated to 64 bits.
// ----------------------------------------------------------------------------
module hsd_affine
   import hsd_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 32
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [COORD_BITS-1:0] x,
   input  logic [COORD_BITS-1:0] y,
   input  coef_bank_type         coef,
   output logic signed [63:0]    w,
   output logic signed [63:0]    nx,
   output logic signed [63:0]    ny,
   output logic                  deg
);

   localparam int PW = COORD_BITS + 1 + COEF_W;

   logic signed [PW-1:0] prod_ff [0:5];
   logic signed [63:0]   w_ff, nx_ff, ny_ff, w_in;
   logic                 deg_ff;

   always_comb begin
      w_in = sat64(128'(prod_ff[4]) + 128'(prod_ff[5]) + (128'(1) << COEF_FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= PW'($signed({1'b0, x})) * PW'($signed(coef[0]));
         prod_ff[1] <= PW'($signed({1'b0, y})) * PW'($signed(coef[1]));
         prod_ff[2] <= PW'($signed({1'b0, x})) * PW'($signed(coef[3]));
         prod_ff[3] <= PW'($signed({1'b0, y})) * PW'($signed(coef[4]));
         prod_ff[4] <= PW'($signed({1'b0, x})) * PW'($signed(coef[6]));
         prod_ff[5] <= PW'($signed({1'b0, y})) * PW'($signed(coef[7]));
         w_ff   <= w_in;
         deg_ff <= (w_in == 64'sd0);
         nx_ff  <= sat64(128'(prod_ff[0]) + 128'(prod_ff[1]) + 128'($signed(coef[2])));
         ny_ff  <= sat64(128'(prod_ff[2]) + 128'(prod_ff[3]) + 128'($signed(coef[5])));
      end
   end

   assign w   = w_ff;
   assign nx  = nx_ff;
   assign ny  = ny_ff;
   assign deg = deg_ff;

endmodule

/* hdl/hsd_div.sv */
// ----------------------------------------------------------------------------
// hsd_div
// Pipelined signed divider, 128 by 64 bits, one quotient bit per stage,
// quotient truncated toward zero and saturated to 64 bits.
// ----------------------------------------------------------------------------
module hsd_div
   import hsd_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic signed [127:0] num,
   input  logic signed [63:0]  den,
   output logic signed [63:0]  quo
);

   logic [127:0] nmag;
   logic [63:0]  dmag;

   logic [63:0] rem_ff [0:QUO_BITS];
   logic [63:0] acc_ff [0:QUO_BITS];
   logic [63:0] dv_ff  [0:QUO_BITS];
   logic        neg_ff [0:QUO_BITS];
   logic        ovf_ff [0:QUO_BITS];
   logic signed [63:0] quo_ff, quo_in;

   always_comb begin
      nmag = num[127] ? 128'(-num) : 128'(num);
      dmag = den[63] ? 64'(-den) : 64'(den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= nmag[127:64];
         acc_ff[0] <= nmag[63:0];
         dv_ff[0]  <= dmag;
         neg_ff[0] <= num[127] ^ den[63];
         ovf_ff[0] <= (nmag[127:64] >= dmag);
      end
   end

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
      logic [64:0] t, d;
      logic        ge;
      logic [63:0] rem_in;
      always_comb begin
         t      = {rem_ff[i], acc_ff[i][63]};
         d      = {1'b0, dv_ff[i]};
         ge     = (t >= d);
         rem_in = ge ? 64'(t - d) : t[63:0];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i+1] <= rem_in;
            acc_ff[i+1] <= {acc_ff[i][62:0], ge};
            dv_ff[i+1]  <= dv_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
   end

   always_comb begin
      if (ovf_ff[QUO_BITS]) begin
         quo_in = neg_ff[QUO_BITS] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else if (neg_ff[QUO_BITS]) begin
         quo_in = (acc_ff[QUO_BITS] > {1'b1, 63'd0}) ? {1'b1, 63'd0}
                                                    : -$signed(acc_ff[QUO_BITS]);
      end else begin
         quo_in = acc_ff[QUO_BITS][63] ? {1'b0, {63{1'b1}}} : $signed(acc_ff[QUO_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

/* hdl/hsd_proj.sv */
// ----------------------------------------------------------------------------
// hsd_proj
// Projective term hx*sx + hy*sy in Q.32: 32-bit partial products,
// recombination, then shift, add and saturate.
// ----------------------------------------------------------------------------
module hsd_proj
   import hsd_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] hx,
   input  logic signed [63:0] sx,
   input  logic signed [63:0] hy,
   input  logic signed [63:0] sy,
   output logic signed [63:0] p
);

   logic signed [63:0]  opa [0:1];
   logic signed [63:0]  opb [0:1];
   logic signed [127:0] full_ff [0:1];
   logic signed [63:0]  p_ff;

   assign opa[0] = hx;
   assign opb[0] = sx;
   assign opa[1] = hy;
   assign opb[1] = sy;

   for (genvar j = 0; j < 2; j++) begin : g_mul
      logic signed [63:0] hh_ff;
      logic signed [65:0] hl_ff, lh_ff;
      logic [63:0]        ll_ff;
      always_ff @(posedge clock) begin
         if (en) begin
            hh_ff <= 64'($signed(opa[j][63:32])) * 64'($signed(opb[j][63:32]));
            hl_ff <= 66'($signed(opa[j][63:32])) * 66'($signed({1'b0, opb[j][31:0]}));
            lh_ff <= 66'($signed({1'b0, opa[j][31:0]})) * 66'($signed(opb[j][63:32]));
            ll_ff <= 64'(opa[j][31:0]) * 64'(opb[j][31:0]);
            full_ff[j] <= (128'(hh_ff) <<< 64) + ((128'(hl_ff) + 128'(lh_ff)) <<< 32)
                        + $signed({64'd0, ll_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= sat64((full_ff[0] >>> INT_FRAC) + (full_ff[1] >>> INT_FRAC));
      end
   end

   assign p = p_ff;

endmodule

/* hdl/hsd_out.sv */
// ----------------------------------------------------------------------------
// hsd_out
// Output stage: scaling by column and row, shift to Q24.24, saturation,
// zeroing for a degenerate denominator.
// ----------------------------------------------------------------------------
module hsd_out
   import hsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [63:0]    sx,
   input  logic signed [63:0]    sy,
   input  logic signed [63:0]    p,
   input  logic [COORD_BITS-1:0] x,
   input  logic [COORD_BITS-1:0] y,
   input  logic                  deg,
   output rsp_type               data
);

   localparam int MW = 64 + COORD_BITS + 1;
   localparam int SH = INT_FRAC - OUT_FRAC;

   logic signed [MW-1:0] m_ff [0:5];
   logic signed [63:0]   sx_ff, sy_ff;
   logic                 deg_ff;
   rsp_type              data_ff;

   function automatic logic signed [COEF_W-1:0] scale(input logic signed [127:0] v,
                                                      input logic z);
      return z ? '0 : sat48(v >>> SH);
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= MW'(sx) * MW'($signed({1'b0, x}));
         m_ff[1] <= MW'(sy) * MW'($signed({1'b0, x}));
         m_ff[2] <= MW'(p)  * MW'($signed({1'b0, x}));
         m_ff[3] <= MW'(sx) * MW'($signed({1'b0, y}));
         m_ff[4] <= MW'(sy) * MW'($signed({1'b0, y}));
         m_ff[5] <= MW'(p)  * MW'($signed({1'b0, y}));
         sx_ff   <= sx;
         sy_ff   <= sy;
         deg_ff  <= deg;
         data_ff.jac_x_gx   <= scale(128'(m_ff[0]), deg_ff);
         data_ff.jac_x_gy   <= scale(128'(m_ff[1]), deg_ff);
         data_ff.jac_x_proj <= scale(128'(m_ff[2]), deg_ff);
         data_ff.jac_y_gx   <= scale(128'(m_ff[3]), deg_ff);
         data_ff.jac_y_gy   <= scale(128'(m_ff[4]), deg_ff);
         data_ff.jac_y_proj <= scale(128'(m_ff[5]), deg_ff);
         data_ff.jac_gx     <= scale(128'(sx_ff), deg_ff);
         data_ff.jac_gy     <= scale(128'(sy_ff), deg_ff);
         data_ff.degenerate <= deg_ff;
      end
   end

   assign data = data_ff;

endmodule

/* hdl/homography_steepest_descent_pixel.sv */
// ----------------------------------------------------------------------------
// homography_steepest_descent_pixel
// Eight steepest-descent values of a homography motion model per pixel.
// ----------------------------------------------------------------------------
// One pixel transaction is accepted per clock; the whole pipeline holds while
// a finished result is not taken. A request passes 1 input register, 2 affine
// stages, 66 divider stages (input, one per quotient bit, output; four
// dividers share the denominator), 3 projective-product stages and 2 output
// stages. Coefficients must be written through the csr port only while no
// transaction is in flight; the block itself does not enforce this.
module homography_steepest_descent_pixel
   import hsd_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   localparam int DLY_XY  = LAT_AFF + LAT_DIV + LAT_PROJ;
   localparam int DLY_DEG = LAT_DIV + LAT_PROJ;
   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC_BITS);

   coef_bank_type          coef_ff;
   logic [LAT_ALL-1:0]     vld_ff;
   logic                   adv;
   req_type                in_ff;
   logic signed [GRAD_W-1:0] gx_ff [0:LAT_AFF-1];
   logic signed [GRAD_W-1:0] gy_ff [0:LAT_AFF-1];
   logic [COORD_BITS-1:0]  x_ff [0:DLY_XY-1];
   logic [COORD_BITS-1:0]  y_ff [0:DLY_XY-1];
   logic                   deg_ff [0:DLY_DEG-1];
   logic signed [63:0]     sxd_ff [0:LAT_PROJ-1];
   logic signed [63:0]     syd_ff [0:LAT_PROJ-1];

   logic signed [63:0] w, nx, ny, sx, sy, hx, hy, p;
   logic               deg;

   assign adv       = !vld_ff[LAT_ALL-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT_ALL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= (i == int'(CSR_COEF_00) || i == int'(CSR_COEF_11)) ? COEF_ONE
                                                                             : '0;
         end
         vld_ff <= '0;
      end else begin
         if (csr_we) begin
            coef_ff[csr_index] <= csr_wdata;
         end
         if (adv) begin
            vld_ff <= {vld_ff[LAT_ALL-2:0], req_valid};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff     <= req_data;
         gx_ff[0]  <= in_ff.grad_x;
         gy_ff[0]  <= in_ff.grad_y;
         x_ff[0]   <= in_ff.col;
         y_ff[0]   <= in_ff.row;
         deg_ff[0] <= deg;
         sxd_ff[0] <= sx;
         syd_ff[0] <= sy;
      end
   end

   for (genvar i = 1; i < LAT_AFF; i++) begin : g_gdly
      always_ff @(posedge clock) begin
         if (adv) begin
            gx_ff[i] <= gx_ff[i-1];
            gy_ff[i] <= gy_ff[i-1];
         end
      end
   end

   for (genvar i = 1; i < DLY_XY; i++) begin : g_xydly
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i] <= x_ff[i-1];
            y_ff[i] <= y_ff[i-1];
         end
      end
   end

   for (genvar i = 1; i < DLY_DEG; i++) begin : g_degdly
      always_ff @(posedge clock) begin
         if (adv) begin
            deg_ff[i] <= deg_ff[i-1];
         end
      end
   end

   for (genvar i = 1; i < LAT_PROJ; i++) begin : g_sdly
      always_ff @(posedge clock) begin
         if (adv) begin
            sxd_ff[i] <= sxd_ff[i-1];
            syd_ff[i] <= syd_ff[i-1];
         end
      end
   end

   hsd_affine #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_affine (
      .clock(clock), .en(adv), .x(in_ff.col), .y(in_ff.row), .coef(coef_ff),
      .w(w), .nx(nx), .ny(ny), .deg(deg)
   );

   hsd_div u_div_sx (
      .clock(clock), .en(adv),
      .num(128'(gx_ff[LAT_AFF-1]) <<< (INT_FRAC - GRAD_FRAC + COEF_FRAC_BITS)),
      .den(w), .quo(sx)
   );

   hsd_div u_div_sy (
      .clock(clock), .en(adv),
      .num(128'(gy_ff[LAT_AFF-1]) <<< (INT_FRAC - GRAD_FRAC + COEF_FRAC_BITS)),
      .den(w), .quo(sy)
   );

   hsd_div u_div_hx (
      .clock(clock), .en(adv), .num(-(128'(nx) <<< INT_FRAC)), .den(w), .quo(hx)
   );

   hsd_div u_div_hy (
      .clock(clock), .en(adv), .num(-(128'(ny) <<< INT_FRAC)), .den(w), .quo(hy)
   );

   hsd_proj u_proj (
      .clock(clock), .en(adv), .hx(hx), .sx(sx), .hy(hy), .sy(sy), .p(p)
   );

   hsd_out u_out (
      .clock(clock), .en(adv),
      .sx(sxd_ff[LAT_PROJ-1]), .sy(syd_ff[LAT_PROJ-1]), .p(p),
      .x(x_ff[DLY_XY-1]), .y(y_ff[DLY_XY-1]), .deg(deg_ff[DLY_DEG-1]),
      .data(rsp_data)
   );

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.jac_gx == 0 && rsp_data.jac_gy == 0 && rsp_data.jac_x_proj == 0)
      else $error("degenerate result carries nonzero values");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("pipeline held without a waiting result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vld_ff) && $stable(in_ff))
      else $error("pipeline moved during a stall");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for homography_steepest_descent_pixel: a queue-fed
// driver, a monitor that checks every result against a bit-exact predictor,
// random gaps on both sides, a long output stall and several coefficient sets.
// ----------------------------------------------------------------------------
module tb;
   import hsd_pkg::*;

   localparam int RSP_W = $bits(rsp_type);

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]    csr_wdata = '0;

   logic signed [COEF_W-1:0] coef_q [NUM_COEF];
   req_type pending_px [$];
   rsp_type expected_jac [$];
   logic    req_fire_d = 1'b0;
   logic    rsp_fire_d = 1'b0;
   int      fail_count = 0;
   int      rsp_count = 0;
   int      send_gap = 0;
   int      recv_stall = 0;
   int      hold_left = 0;
   bit      hold_done = 1'b0;
   bit      quiet_mode = 1'b0;
   string   field_name [8] = '{"jac_x_gx", "jac_x_gy", "jac_x_proj", "jac_y_gx",
                               "jac_y_gy", "jac_y_proj", "jac_gx", "jac_gy"};

   homography_steepest_descent_pixel uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic signed [127:0] clamp_to(logic signed [127:0] v, int bits);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (bits - 1)) - 128'sd1;
      lo_lim = -(128'sd1 <<< (bits - 1));
      return (v > hi_lim) ? hi_lim : ((v < lo_lim) ? lo_lim : v);
   endfunction

   function automatic rsp_type predict_jacobian(req_type t);
      logic signed [127:0] x, y, gx, gy, w, nx, ny, sx, sy, hx, hy, p;
      logic signed [127:0] c [NUM_COEF];
      rsp_type r;
      for (int i = 0; i < NUM_COEF; i++) c[i] = 128'(coef_q[i]);
      x = 128'(t.col);
      y = 128'(t.row);
      gx = 128'(t.grad_x);
      gy = 128'(t.grad_y);
      r = '0;
      w = clamp_to(x * c[6] + y * c[7] + (128'sd1 <<< 32), 64);
      if (w == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      nx = clamp_to(x * c[0] + y * c[1] + c[2], 64);
      ny = clamp_to(x * c[3] + y * c[4] + c[5], 64);
      sx = clamp_to((gx <<< 48) / w, 64);
      sy = clamp_to((gy <<< 48) / w, 64);
      hx = clamp_to((-(nx <<< 32)) / w, 64);
      hy = clamp_to((-(ny <<< 32)) / w, 64);
      p = clamp_to(((hx * sx) >>> 32) + ((hy * sy) >>> 32), 64);
      r.jac_x_gx   = COEF_W'(clamp_to((sx * x) >>> 8, 48));
      r.jac_x_gy   = COEF_W'(clamp_to((sy * x) >>> 8, 48));
      r.jac_x_proj = COEF_W'(clamp_to((p * x) >>> 8, 48));
      r.jac_y_gx   = COEF_W'(clamp_to((sx * y) >>> 8, 48));
      r.jac_y_gy   = COEF_W'(clamp_to((sy * y) >>> 8, 48));
      r.jac_y_proj = COEF_W'(clamp_to((p * y) >>> 8, 48));
      r.jac_gx     = COEF_W'(clamp_to(sx >>> 8, 48));
      r.jac_gy     = COEF_W'(clamp_to(sy >>> 8, 48));
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      logic    nv;
      req_type nd;
      nv = req_valid;
      nd = req_data;
      if (!reset && !(req_valid && !req_fire_d)) begin
         nv = 1'b0;
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
         end else if (pending_px.size() > 0) begin
            nv = 1'b1;
            nd = pending_px.pop_front();
            send_gap = quiet_mode ? 0 : $urandom_range(0, 15);
         end
      end
      req_valid <= nv;
      req_data <= nd;
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && quiet_mode && rsp_count >= 400) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (rsp_fire_d) recv_stall = quiet_mode ? 0 : $urandom_range(0, 15);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall = recv_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      logic [RSP_W-1:0] got_bits, want_bits;
      req_fire_d <= req_valid && req_ready && !reset;
      rsp_fire_d <= rsp_valid && rsp_ready && !reset;
      if (!reset && req_valid && req_ready) expected_jac.push_back(predict_jacobian(req_data));
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count = rsp_count + 1;
         if (expected_jac.size() == 0) begin
            $display("%0t: result with no transaction outstanding: %h", $time, rsp_data);
            fail_count = fail_count + 1;
         end else begin
            want = expected_jac.pop_front();
            got_bits = rsp_data;
            want_bits = want;
            for (int i = 0; i < 8; i++) begin
               if (got_bits[RSP_W-1-48*i -: 48] !== want_bits[RSP_W-1-48*i -: 48]) begin
                  $display("%0t: %s expected %h actual %h", $time, field_name[i],
                           want_bits[RSP_W-1-48*i -: 48], got_bits[RSP_W-1-48*i -: 48]);
                  fail_count = fail_count + 1;
               end
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $display("%0t: degenerate expected %b actual %b", $time,
                        want.degenerate, rsp_data.degenerate);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   task automatic write_coef(int idx, logic [COEF_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx[CSR_IDX_W-1:0];
      csr_wdata <= val;
      coef_q[idx] = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      wait (pending_px.size() == 0 && !req_valid && expected_jac.size() == 0);
      repeat (LAT_ALL + 4) @(negedge clock);
   endtask

   task automatic add_px(int col, int row, logic [31:0] gx, logic [31:0] gy);
      req_type t;
      t.col = col[COORD_BITS-1:0];
      t.row = row[COORD_BITS-1:0];
      t.grad_x = gx;
      t.grad_y = gy;
      pending_px.push_back(t);
   endtask

   function automatic logic [COEF_W-1:0] rand48();
      return COEF_W'({$urandom(), $urandom()});
   endfunction

   initial begin
      int s, mode;
      logic signed [COEF_W-1:0] cmax, cmin;
      cmax = {1'b0, {(COEF_W-1){1'b1}}};
      cmin = {1'b1, {(COEF_W-1){1'b0}}};
      for (int i = 0; i < NUM_COEF; i++) coef_q[i] = '0;
      coef_q[0] = 48'sd1 <<< 32;
      coef_q[4] = 48'sd1 <<< 32;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // identity warp, field extremes
      add_px(0, 0, 32'h0001_0000, 32'hFFFF_0000);
      add_px(8191, 8191, 32'h7FFF_FFFF, 32'h8000_0000);
      add_px(8191, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      add_px(0, 8191, 32'hFFFF_FFFF, 32'h0000_0001);
      add_px(4096, 1, 32'h0, 32'h0);
      add_px(1234, 5678, 32'h1234_5678, 32'hEDCB_A988);
      wait_idle();

      // zero denominator at x = 1
      write_coef(6, -(48'sd1 <<< 32));
      write_coef(7, 48'sd0);
      write_coef(2, 48'sd5 <<< 32);
      write_coef(5, -(48'sd3 <<< 32));
      write_coef(1, rand48());
      write_coef(3, rand48());
      add_px(1, 0, 32'h0003_0000, 32'h0004_0000);
      add_px(1, 77, 32'h7FFF_FFFF, 32'h8000_0000);
      add_px(0, 9, 32'h0002_0000, 32'hFFFE_0000);
      add_px(2, 3, 32'h8000_0000, 32'h8000_0000);
      wait_idle();

      // coefficient extremes, to drive saturation
      for (int i = 0; i < NUM_COEF; i++) write_coef(i, (i % 2) ? cmin : cmax);
      add_px(8191, 8191, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_px(1, 1, 32'h8000_0000, 32'h0000_0001);
      add_px(0, 0, 32'h0000_0001, 32'hFFFF_FFFF);
      add_px(8191, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      wait_idle();
      for (int i = 0; i < NUM_COEF; i++) write_coef(i, (i % 2) ? cmax : cmin);
      add_px(8191, 8191, 32'h8000_0000, 32'h7FFF_FFFF);
      add_px(0, 8191, 32'h0001_0000, 32'h0001_0000);
      add_px(3, 2, 32'h7FFF_FFFF, 32'h8000_0000);
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         mode = $urandom_range(0, 3);
         s = $urandom_range(0, 12);
         quiet_mode = (ph % 4 == 3);
         for (int i = 0; i < NUM_COEF; i++) begin
            if (mode == 0) write_coef(i, rand48());
            else if (i >= 6) write_coef(i, $signed(rand48()) >>> $urandom_range(20, 40));
            else write_coef(i, $signed(rand48()) >>> $urandom_range(4, 20));
         end
         if (mode == 3) begin
            write_coef(6, -((48'sd1 <<< 32) >>> s));
            write_coef(7, 48'sd0);
         end
         for (int k = 0; k < 122; k++) begin
            if (mode == 3 && $urandom_range(0, 4) == 0)
               add_px(1 << s, $urandom_range(0, 8191), $urandom(), $urandom());
            else if ($urandom_range(0, 3) == 0)
               add_px($urandom_range(0, 15), $urandom_range(0, 15),
                      $signed($urandom()) >>> $urandom_range(0, 31), $urandom());
            else
               add_px($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom(),
                      $signed($urandom()) >>> $urandom_range(0, 31));
         end
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
hdl/hsd_pkg.sv
hdl/hsd_affine.sv
hdl/hsd_div.sv
hdl/hsd_proj.sv
hdl/hsd_out.sv
hdl/homography_steepest_descent_pixel.sv
tb/sv/tb.sv
